>>> sv/symmetric_epipolar_distance_core_assert.svh
// Assertion macros for the symmetric epipolar distance core.
`ifndef SYMMETRIC_EPIPOLAR_DISTANCE_CORE_ASSERT_SVH
`define SYMMETRIC_EPIPOLAR_DISTANCE_CORE_ASSERT_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define SED_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define SED_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> sv/sed_pkg.sv
// Package: widths, latencies and payload types of the symmetric epipolar distance core.
package sed_pkg;

  localparam int COORD_WIDTH = 24;
  localparam int COEF_WIDTH  = 48;
  localparam int COORD_FRAC  = 8;
  localparam int OUT_FRAC    = 16;
  localparam int DIST_WIDTH  = 32;

  // Split multiplier: chunk size of each partial product and its latency.
  localparam int MUL_CHUNK = 32;
  localparam int MUL_LAT   = 5;

  // Internal exact-integer widths.
  localparam int LINE_WIDTH = COEF_WIDTH + COORD_WIDTH + 2;
  localparam int NUM_WIDTH  = COORD_WIDTH + LINE_WIDTH + 2;
  localparam int NORM_WIDTH = 2 * LINE_WIDTH;
  localparam int RHS_SHIFT  = 2 * (OUT_FRAC - COORD_FRAC);
  localparam int RHS_WIDTH  = 2 * NUM_WIDTH + RHS_SHIFT;
  localparam int SAT_SHIFT  = 2 * DIST_WIDTH;
  localparam int ROOT_WIDTH = (RHS_WIDTH > NORM_WIDTH + SAT_SHIFT + 1) ?
                              RHS_WIDTH : NORM_WIDTH + SAT_SHIFT + 1;

  // Latency of the line and norm section.
  localparam int LINES_LAT = 2 * MUL_LAT + 3;

  typedef struct packed {
    logic [2*COORD_WIDTH-1:0]      first_xy;
    logic [2*COORD_WIDTH-1:0]      second_xy;
    logic signed [COEF_WIDTH-1:0]  f00;
    logic signed [COEF_WIDTH-1:0]  f01;
    logic signed [COEF_WIDTH-1:0]  f02;
    logic signed [COEF_WIDTH-1:0]  f10;
    logic signed [COEF_WIDTH-1:0]  f11;
    logic signed [COEF_WIDTH-1:0]  f12;
    logic signed [COEF_WIDTH-1:0]  f20;
    logic signed [COEF_WIDTH-1:0]  f21;
    logic signed [COEF_WIDTH-1:0]  f22;
  } req_t;

  typedef struct packed {
    logic [DIST_WIDTH-1:0] distance;
    logic                  saturated;
  } rsp_t;

  // Numerator magnitude and shorter-line squared norm, handed to the root stage.
  typedef struct packed {
    logic [NUM_WIDTH-1:0]  num_mag;
    logic [NORM_WIDTH-1:0] norm_min;
  } lines_t;

endpackage

>>> sv/sed_mul.sv
// Pipelined signed multiplier built from 32x32 partial products.
module sed_mul import sed_pkg::*; #(
  parameter int AW = 24,
  parameter int BW = 48
) (
  input  logic                    clk,
  input  logic                    adv,
  input  logic signed [AW-1:0]    a,
  input  logic signed [BW-1:0]    b,
  output logic signed [AW+BW-1:0] p
);

  localparam int PW  = AW + BW;
  localparam int NA  = (AW + MUL_CHUNK - 1) / MUL_CHUNK;
  localparam int NB  = (BW + MUL_CHUNK - 1) / MUL_CHUNK;
  localparam int AMW = NA * MUL_CHUNK;
  localparam int BMW = NB * MUL_CHUNK;

  logic [AW-1:0]          a_abs;
  logic [BW-1:0]          b_abs;
  logic [AMW-1:0]         a_mag;
  logic [BMW-1:0]         b_mag;
  logic                   neg1, neg2, neg3, neg4;
  logic [2*MUL_CHUNK-1:0] part [NA][NB];
  logic [PW-1:0]          row [NA];
  logic [PW-1:0]          row_next [NA];
  logic [PW-1:0]          mag, mag_next;

  // Take magnitudes; the most negative value maps to its unsigned magnitude
  assign a_abs = a[AW-1] ? AW'(-a) : AW'(a);
  assign b_abs = b[BW-1] ? BW'(-b) : BW'(b);

  // Sum partial products per row, then the rows
  always_comb begin
    for (int i = 0; i < NA; i++) begin
      row_next[i] = '0;
      for (int j = 0; j < NB; j++) begin
        row_next[i] = row_next[i] + (PW'(part[i][j]) << (j * MUL_CHUNK));
      end
    end
    mag_next = '0;
    for (int i = 0; i < NA; i++) begin
      mag_next = mag_next + (row[i] << (i * MUL_CHUNK));
    end
  end

  // Advance the five stages together
  always_ff @(posedge clk) begin
    if (adv) begin
      a_mag <= AMW'(a_abs);
      b_mag <= BMW'(b_abs);
      neg1  <= a[AW-1] ^ b[BW-1];
      for (int i = 0; i < NA; i++) begin
        for (int j = 0; j < NB; j++) begin
          part[i][j] <= a_mag[i*MUL_CHUNK +: MUL_CHUNK] * b_mag[j*MUL_CHUNK +: MUL_CHUNK];
        end
      end
      neg2 <= neg1;
      row  <= row_next;
      neg3 <= neg2;
      mag  <= mag_next;
      neg4 <= neg3;
      p    <= neg4 ? -mag : mag;
    end
  end

endmodule

>>> sv/sed_lines.sv
// Epipolar lines, numerator and shorter-line squared norm.
module sed_lines import sed_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   adv,
  input  logic   in_valid,
  input  req_t   req,
  output logic   out_valid,
  output lines_t lines
);

  localparam int CW = COORD_WIDTH;
  localparam int FW = COEF_WIDTH;
  localparam int LW = LINE_WIDTH;
  localparam int NW = NUM_WIDTH;
  localparam int SW = NORM_WIDTH;

  logic signed [CW-1:0]      x1, y1, x2, y2;
  logic signed [FW-1:0]      fm [3][3];
  logic signed [FW+CW-1:0]   pa_x [3];
  logic signed [FW+CW-1:0]   pa_y [3];
  logic signed [FW+CW-1:0]   pb_x [3];
  logic signed [FW+CW-1:0]   pb_y [3];
  logic signed [FW-1:0]      ha_dl [MUL_LAT][3];
  logic signed [FW-1:0]      hb_dl [MUL_LAT][3];
  logic signed [CW-1:0]      x2_dl [MUL_LAT];
  logic signed [CW-1:0]      y2_dl [MUL_LAT];
  logic signed [LW-1:0]      la [3];
  logic signed [LW-1:0]      lb [3];
  logic signed [CW-1:0]      x2_b, y2_b;
  logic signed [CW+LW-1:0]   pn_x, pn_y;
  logic signed [2*LW-1:0]    sq_a0, sq_a1, sq_b0, sq_b1;
  logic signed [LW-1:0]      la2_dl [MUL_LAT];
  logic signed [NW-1:0]      num;
  logic [SW-1:0]             sa, sb, smin;
  logic [LINES_LAT-1:0]      vpipe;

  // Unpack points and matrix
  assign x1 = signed'(req.first_xy[2*CW-1:CW]);
  assign y1 = signed'(req.first_xy[CW-1:0]);
  assign x2 = signed'(req.second_xy[2*CW-1:CW]);
  assign y2 = signed'(req.second_xy[CW-1:0]);
  assign fm[0][0] = req.f00;
  assign fm[0][1] = req.f01;
  assign fm[0][2] = req.f02;
  assign fm[1][0] = req.f10;
  assign fm[1][1] = req.f11;
  assign fm[1][2] = req.f12;
  assign fm[2][0] = req.f20;
  assign fm[2][1] = req.f21;
  assign fm[2][2] = req.f22;

  // Products for F*p and F^T*q
  for (genvar i = 0; i < 3; i++) begin : g_line_mul
    sed_mul #(.AW(FW), .BW(CW)) u_ax (.clk, .adv, .a(fm[i][0]), .b(x1), .p(pa_x[i]));
    sed_mul #(.AW(FW), .BW(CW)) u_ay (.clk, .adv, .a(fm[i][1]), .b(y1), .p(pa_y[i]));
    sed_mul #(.AW(FW), .BW(CW)) u_bx (.clk, .adv, .a(fm[0][i]), .b(x2), .p(pb_x[i]));
    sed_mul #(.AW(FW), .BW(CW)) u_by (.clk, .adv, .a(fm[1][i]), .b(y2), .p(pb_y[i]));
  end

  // Delay homogeneous terms and the second point alongside the multipliers
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        ha_dl[0][i] <= fm[i][2];
        hb_dl[0][i] <= fm[2][i];
      end
      x2_dl[0] <= x2;
      y2_dl[0] <= y2;
      for (int k = 1; k < MUL_LAT; k++) begin
        ha_dl[k] <= ha_dl[k-1];
        hb_dl[k] <= hb_dl[k-1];
        x2_dl[k] <= x2_dl[k-1];
        y2_dl[k] <= y2_dl[k-1];
      end
    end
  end

  // Sum the line components; the homogeneous coordinate is one in Q.8
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        la[i] <= LW'(pa_x[i]) + LW'(pa_y[i]) + (LW'(ha_dl[MUL_LAT-1][i]) <<< COORD_FRAC);
        lb[i] <= LW'(pb_x[i]) + LW'(pb_y[i]) + (LW'(hb_dl[MUL_LAT-1][i]) <<< COORD_FRAC);
      end
      x2_b <= x2_dl[MUL_LAT-1];
      y2_b <= y2_dl[MUL_LAT-1];
    end
  end

  // Numerator products and squared line components
  sed_mul #(.AW(CW), .BW(LW)) u_nx  (.clk, .adv, .a(x2_b),  .b(la[0]), .p(pn_x));
  sed_mul #(.AW(CW), .BW(LW)) u_ny  (.clk, .adv, .a(y2_b),  .b(la[1]), .p(pn_y));
  sed_mul #(.AW(LW), .BW(LW)) u_sa0 (.clk, .adv, .a(la[0]), .b(la[0]), .p(sq_a0));
  sed_mul #(.AW(LW), .BW(LW)) u_sa1 (.clk, .adv, .a(la[1]), .b(la[1]), .p(sq_a1));
  sed_mul #(.AW(LW), .BW(LW)) u_sb0 (.clk, .adv, .a(lb[0]), .b(lb[0]), .p(sq_b0));
  sed_mul #(.AW(LW), .BW(LW)) u_sb1 (.clk, .adv, .a(lb[1]), .b(lb[1]), .p(sq_b1));

  // Hold the third line component for the numerator
  always_ff @(posedge clk) begin
    if (adv) begin
      la2_dl[0] <= la[2];
      for (int k = 1; k < MUL_LAT; k++) begin
        la2_dl[k] <= la2_dl[k-1];
      end
    end
  end

  // Numerator and both squared norms
  always_ff @(posedge clk) begin
    if (adv) begin
      num <= NW'(pn_x) + NW'(pn_y) + (NW'(la2_dl[MUL_LAT-1]) <<< COORD_FRAC);
      sa  <= sq_a0[SW-1:0] + sq_a1[SW-1:0];
      sb  <= sq_b0[SW-1:0] + sq_b1[SW-1:0];
    end
  end

  // Pick the shorter line; a zero norm becomes one LSB
  assign smin = (sa <= sb) ? sa : sb;

  always_ff @(posedge clk) begin
    if (adv) begin
      lines.num_mag  <= num[NW-1] ? NW'(-num) : NW'(num);
      lines.norm_min <= (smin == '0) ? SW'(1) : smin;
    end
  end

  // Valid bits travel with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      vpipe <= '0;
    end else if (adv) begin
      vpipe <= {vpipe[LINES_LAT-2:0], in_valid};
    end
  end

  assign out_valid = vpipe[LINES_LAT-1];

endmodule

>>> sv/sed_root.sv
// Saturation check and bit-per-stage search for the Q16.16 distance.
module sed_root import sed_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   adv,
  input  logic   in_valid,
  input  lines_t lines,
  output logic   out_valid,
  output rsp_t   rsp
);

  localparam int NW = NUM_WIDTH;
  localparam int SW = NORM_WIDTH;
  localparam int MW = ROOT_WIDTH;
  localparam int EW = NORM_WIDTH + DIST_WIDTH;

  logic signed [2*NW+1:0]  sq;
  logic [SW-1:0]           s_dl [MUL_LAT];
  logic [MUL_LAT-1:0]      v_dl;
  logic [MW-1:0]           rhs;
  logic [MW-1:0]           rem_st  [DIST_WIDTH];
  logic [EW-1:0]           e_st    [DIST_WIDTH];
  logic [SW-1:0]           s_st    [DIST_WIDTH];
  logic [DIST_WIDTH-1:0]   dist_st [DIST_WIDTH+1];
  logic                    sat_st  [DIST_WIDTH+1];
  logic [DIST_WIDTH:0]     v_st;

  // Square the numerator magnitude
  sed_mul #(.AW(NW+1), .BW(NW+1)) u_sq (
    .clk, .adv,
    .a(signed'({1'b0, lines.num_mag})),
    .b(signed'({1'b0, lines.num_mag})),
    .p(sq)
  );

  // Hold the norm and valid alongside the multiplier
  always_ff @(posedge clk) begin
    if (adv) begin
      s_dl[0] <= lines.norm_min;
      for (int k = 1; k < MUL_LAT; k++) begin
        s_dl[k] <= s_dl[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_dl <= '0;
    end else if (adv) begin
      v_dl <= {v_dl[MUL_LAT-2:0], in_valid};
    end
  end

  assign rhs = MW'(sq[2*NW-1:0]) << RHS_SHIFT;

  // Saturate when the norm times 2^64 does not exceed the scaled square
  always_ff @(posedge clk) begin
    if (adv) begin
      rem_st[0]  <= rhs;
      e_st[0]    <= '0;
      s_st[0]    <= s_dl[MUL_LAT-1];
      dist_st[0] <= '0;
      sat_st[0]  <= (MW'(s_dl[MUL_LAT-1]) << SAT_SHIFT) <= rhs;
    end
  end

  // One result bit per stage, most significant first
  for (genvar j = 0; j < DIST_WIDTH; j++) begin : g_step
    localparam int B = DIST_WIDTH - 1 - j;
    logic [MW-1:0] test;
    logic          take;

    assign test = (MW'(e_st[j]) << (B + 1)) + (MW'(s_st[j]) << (2 * B));
    assign take = rem_st[j] >= test;

    always_ff @(posedge clk) begin
      if (adv) begin
        dist_st[j+1] <= dist_st[j] | (DIST_WIDTH'(take) << B);
        sat_st[j+1]  <= sat_st[j];
      end
    end

    if (j < DIST_WIDTH - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (adv) begin
          rem_st[j+1] <= take ? rem_st[j] - test : rem_st[j];
          e_st[j+1]   <= take ? e_st[j] + (EW'(s_st[j]) << B) : e_st[j];
          s_st[j+1]   <= s_st[j];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_st <= '0;
    end else if (adv) begin
      v_st <= {v_st[DIST_WIDTH-1:0], v_dl[MUL_LAT-1]};
    end
  end

  assign out_valid     = v_st[DIST_WIDTH];
  assign rsp.distance  = sat_st[DIST_WIDTH] ? '1 : dist_st[DIST_WIDTH];
  assign rsp.saturated = sat_st[DIST_WIDTH];

endmodule

>>> sv/symmetric_epipolar_distance_core.sv
// Top level of the symmetric epipolar distance core: pipeline, output buffer, checks.
// Takes one correspondence (two Q16.8 points and a Q2.46 fundamental matrix) per clock while
// req_ready is high and returns the larger point-to-line distance in unsigned Q16.16,
// clamped to all ones with saturated set when it does not fit. Throughput is one item per
// cycle while the skid entry is empty; the path from input to result register has 52 register
// stages: two split multipliers for the lines and norms, a third for the squared numerator,
// adder stages, and a 32-stage restoring search that settles one result bit per stage. A
// two-entry output buffer lets the pipeline keep accepting items after the result side
// stalls, until its skid entry fills.
module symmetric_epipolar_distance_core import sed_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_ready,
  output rsp_t rsp
);

  logic   adv;
  logic   lines_valid;
  lines_t lines;
  logic   pipe_valid;
  rsp_t   pipe_rsp;
  logic   skid_valid;
  rsp_t   skid;

  // Pipeline advances whenever the skid entry is free
  assign adv       = !skid_valid;
  assign req_ready = adv;

  sed_lines u_lines (
    .clk, .rst, .adv,
    .in_valid (req_valid),
    .req,
    .out_valid(lines_valid),
    .lines
  );

  sed_root u_root (
    .clk, .rst, .adv,
    .in_valid (lines_valid),
    .lines,
    .out_valid(pipe_valid),
    .rsp      (pipe_rsp)
  );

  // Output register with one skid entry
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (!rsp_valid || rsp_ready) begin
        if (skid_valid) begin
          rsp_valid  <= 1'b1;
          skid_valid <= 1'b0;
        end else begin
          rsp_valid <= pipe_valid;
        end
      end else if (pipe_valid && adv) begin
        skid_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rsp_valid || rsp_ready) begin
      rsp <= skid_valid ? skid : pipe_rsp;
    end
    if (rsp_valid && !rsp_ready && adv) begin
      skid <= pipe_rsp;
    end
  end

`include "symmetric_epipolar_distance_core_assert.svh"

  // Clamped results carry the all-ones code
  `SED_ASSERT_NOW(a_sat_ones, rsp_valid && rsp.saturated, rsp.distance == '1, "saturated result not all ones")
  // A filled skid entry implies a pending result
  `SED_ASSERT_NOW(a_skid_behind, skid_valid, rsp_valid, "skid entry without output item")
  // The skid entry is not dropped while the output stalls
  `SED_ASSERT_NEXT(a_skid_hold, skid_valid && !rsp_ready, skid_valid, "skid item lost")

endmodule
